// ===== src/ptc_pkg.sv =====
package ptc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_W     = 7;
    localparam int COUNT_MAX   = 127;
    localparam int COUNT_MID   = (COUNT_MAX + 1) / 2;
    localparam int GAIN_W      = 4;
    localparam int GAIN_MAX    = 15;
    localparam int INT_W       = 32;
    localparam int IDX_W       = 4;
    localparam int AVG_DROP    = 2;
    localparam int AVG_LAST    = 10;
    localparam int AVG_SHIFT   = 3;
    localparam int SUM_W       = 13;
    localparam int OFFSET_W    = 11;
    localparam int OFFSET_ADD  = 20;
    localparam int PI_SHIFT_A  = 6;
    localparam int PI_SHIFT_B  = 8;
    localparam int NEXT_W      = 28;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int STATUS_W    = 3;

    // command kinds on the input side
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_FULL   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_AVG    = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED = 3'd0,
        ST_IGNORED = 3'd1,
        ST_STEP    = 3'd2,
        ST_FOUND   = 3'd3,
        ST_AVG     = 3'd4,
        ST_DONE    = 3'd5
    } t_status;

    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [INT_W-1:0] integral;
        logic [COUNT_W-1:0]      count;
        logic [GAIN_W-1:0]       gain;
        logic                    top_retry;
    } t_pi_res;

endpackage

// ===== src/proximity_crosstalk_calibrator_top.sv =====
// path: an accepted request is held in the input register, then registered into the
//   result register; while a result waits on i_m_tready, both registers hold
// throughput: one request per cycle unless held; the whole search or averaging step of an
//   item is one pass of adders and compares between the input and result registers
// reset (i_rst_n low at a clock edge): both stages empty, phase idle, target 100,
//   full range 1023, fine count 0, fine gain 1, integral and averager cleared
module proximity_crosstalk_calibrator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input request stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ptc_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // [9:0] sample, [15:10] zero
    input  logic [0:0]                          i_s_tuser,   // [0] kind
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ptc_pkg::OUT_TDATA_W-1:0]     o_m_tdata,   // [6:0] fine_count,
                                                             // [10:7] fine_gain,
                                                             // [21:11] offset_value,
                                                             // [23:22] zero
    output logic [ptc_pkg::STATUS_W-1:0]        o_m_tuser,   // [2:0] status
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [ptc_pkg::SAMPLE_BITS-1:0]     i_cfg_data
);
    import ptc_pkg::*;

    // configuration
    logic [SAMPLE_BITS-1:0] r_target;
    logic [SAMPLE_BITS-1:0] r_full;

    // calibration state
    t_phase                  r_phase, n_phase;
    logic                    r_first_pending, n_first_pending;
    logic                    r_top_retry, n_top_retry;
    logic                    r_pi_mode, n_pi_mode;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [GAIN_W-1:0]       r_gain, n_gain;
    logic [COUNT_W-1:0]      r_low, n_low;
    logic [COUNT_W-1:0]      r_high, n_high;
    logic signed [INT_W-1:0] r_integral, n_integral;
    logic [IDX_W-1:0]        r_avg_idx, n_avg_idx;
    logic [SUM_W-1:0]        r_sum, n_sum;

    // result register (count and gain come straight from the state)
    logic                    r_out_valid;
    t_status                 r_status, n_status;
    logic [OFFSET_W-1:0]     r_offset, n_offset;

    // input stage
    logic  w_in_valid;
    t_item w_item;
    logic  w_take;
    logic  w_adv;

    assign w_take = !r_out_valid || i_m_tready;
    assign w_adv  = w_in_valid && w_take;

    ptc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (w_take),
        .o_valid    (w_in_valid),
        .o_item     (w_item)
    );

    // PI update of the fine count and gain
    t_pi_res w_pi;

    ptc_pi_step u_pi_step (
        .i_sample   (w_item.sample),
        .i_target   (r_target),
        .i_count    (r_count),
        .i_gain     (r_gain),
        .i_integral (r_integral),
        .o_res      (w_pi)
    );

    // search decode
    logic                 w_start;
    logic                 w_zero;
    logic                 w_le;
    logic                 w_cnt_nz;
    logic                 w_try_done;
    logic                 w_hit;
    logic                 w_finish;
    logic                 w_step;
    logic                 w_new_high;
    logic                 w_use_pi;
    logic [COUNT_W-1:0]   w_low_eff;
    logic [COUNT_W-1:0]   w_high_eff;
    logic [COUNT_W:0]     w_inc;
    logic [COUNT_W:0]     w_mid_sum;
    logic [COUNT_W-1:0]   w_bis_next;

    assign w_start    = (w_item.kind == KIND_START);
    assign w_zero     = (w_item.sample == '0);
    assign w_le       = (w_item.sample <= r_target);
    assign w_cnt_nz   = (r_count != '0);
    // a pending last try ends the search on any nonzero reading
    assign w_try_done = r_top_retry && !w_zero;
    assign w_hit      = w_cnt_nz ? (!w_zero && (w_le || r_count == r_low || r_count == r_high))
                                 : w_le;
    assign w_finish   = !r_first_pending && (w_try_done || w_hit);
    assign w_step     = !r_first_pending && !w_finish;
    // a zero reading with a nonzero count switches to bisection
    assign w_new_high = w_cnt_nz && w_zero;
    assign w_use_pi   = r_pi_mode && !w_new_high;

    assign w_low_eff  = !w_le ? r_count : r_low;
    assign w_high_eff = w_new_high ? r_count : r_high;
    assign w_inc      = {1'b0, r_count} + (COUNT_W+1)'(1);
    assign w_mid_sum  = {1'b0, w_low_eff} + {1'b0, w_high_eff};

    always_comb begin
        if (w_item.sample < r_full && !w_le) begin
            if (w_inc > (COUNT_W+1)'(COUNT_MAX)) begin
                w_bis_next = COUNT_W'(COUNT_MAX);
            end else begin
                w_bis_next = w_inc[COUNT_W-1:0];
            end
        end else begin
            w_bis_next = w_mid_sum[COUNT_W:1];
        end
    end

    // averaging decode: two readings dropped, eight summed
    logic [IDX_W-1:0]    w_idx_inc;
    logic [SUM_W-1:0]    w_sum_add;
    logic                w_avg_done;
    logic [OFFSET_W-1:0] w_avg_offset;

    assign w_idx_inc    = r_avg_idx + IDX_W'(1);
    assign w_sum_add    = (r_avg_idx >= IDX_W'(AVG_DROP))
                        ? r_sum + SUM_W'(w_item.sample) : r_sum;
    assign w_avg_done   = (w_idx_inc >= IDX_W'(AVG_LAST));
    assign w_avg_offset = OFFSET_W'(w_sum_add >> AVG_SHIFT) + OFFSET_W'(OFFSET_ADD);

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        if (w_adv) begin
            if (w_start) begin
                n_phase = PH_SEARCH;
            end else begin
                unique case (r_phase)
                    PH_SEARCH: if (w_finish)   n_phase = PH_AVG;
                    PH_AVG:    if (w_avg_done) n_phase = PH_DONE;
                    default:   n_phase = r_phase;
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        n_first_pending = r_first_pending;
        n_top_retry     = r_top_retry;
        n_pi_mode       = r_pi_mode;
        n_count         = r_count;
        n_gain          = r_gain;
        n_low           = r_low;
        n_high          = r_high;
        n_integral      = r_integral;
        n_avg_idx       = r_avg_idx;
        n_sum           = r_sum;
        n_status        = r_status;
        n_offset        = r_offset;
        if (w_adv) begin
            n_offset = '0;
            n_status = ST_IGNORED;
            if (w_start) begin
                n_first_pending = 1'b1;
                n_top_retry     = 1'b0;
                n_pi_mode       = 1'b1;
                n_count         = '0;
                n_gain          = GAIN_W'(1);
                n_low           = '0;
                n_high          = COUNT_W'(COUNT_MAX);
                n_integral      = '0;
                n_avg_idx       = '0;
                n_sum           = '0;
                n_status        = ST_STARTED;
            end else begin
                unique case (r_phase)
                    PH_SEARCH: begin
                        if (r_first_pending) begin
                            // first reading after a start is thrown away
                            n_first_pending = 1'b0;
                        end else if (w_finish) begin
                            if (!w_try_done) n_top_retry = 1'b0;
                            n_avg_idx = '0;
                            n_sum     = '0;
                            n_status  = ST_FOUND;
                        end else begin
                            n_status = ST_STEP;
                            n_high   = w_high_eff;
                            if (w_use_pi) begin
                                n_integral  = w_pi.integral;
                                n_count     = w_pi.count;
                                n_gain      = w_pi.gain;
                                n_top_retry = w_pi.top_retry;
                            end else begin
                                n_pi_mode   = 1'b0;
                                n_low       = w_low_eff;
                                n_count     = w_bis_next;
                                n_top_retry = 1'b0;
                            end
                        end
                    end
                    PH_AVG: begin
                        n_sum     = w_sum_add;
                        n_avg_idx = w_idx_inc;
                        if (w_avg_done) begin
                            n_offset = w_avg_offset;
                            n_status = ST_DONE;
                        end else begin
                            n_status = ST_AVG;
                        end
                    end
                    default: n_status = ST_IGNORED;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_first_pending <= 1'b1;
            r_top_retry     <= 1'b0;
            r_pi_mode       <= 1'b1;
            r_count         <= '0;
            r_gain          <= GAIN_W'(1);
            r_low           <= '0;
            r_high          <= COUNT_W'(COUNT_MAX);
            r_integral      <= '0;
            r_avg_idx       <= '0;
            r_sum           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_first_pending <= n_first_pending;
            r_top_retry     <= n_top_retry;
            r_pi_mode       <= n_pi_mode;
            r_count         <= n_count;
            r_gain          <= n_gain;
            r_low           <= n_low;
            r_high          <= n_high;
            r_integral      <= n_integral;
            r_avg_idx       <= n_avg_idx;
            r_sum           <= n_sum;
            if (w_take) r_out_valid <= w_in_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_offset <= n_offset;
    end

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= SAMPLE_BITS'(100);
            r_full   <= SAMPLE_BITS'(1023);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET: r_target <= i_cfg_data;
                CFG_FULL:   r_full   <= i_cfg_data;
                default:    r_target <= r_target;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {(OUT_TDATA_W - OFFSET_W - GAIN_W - COUNT_W)'(0),
                         r_offset, r_gain, r_count};

    // gain never leaves 1..15
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain != '0)
        else $error("fine gain dropped to zero");

    // only a done result carries an offset, and it includes the fixed add
    a_offset_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_status == ST_DONE) |-> r_offset >= OFFSET_W'(OFFSET_ADD))
        else $error("done offset below fixed add");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_status != ST_DONE) |-> r_offset == '0)
        else $error("offset set on a result that is not done");

    // a start always lands in a fresh search
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_start) |=> (r_phase == PH_SEARCH && r_count == '0 && r_first_pending))
        else $error("start did not restart the search");

    a_avg_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_AVG) |-> r_avg_idx < IDX_W'(AVG_LAST))
        else $error("averaging ran past its last reading");

endmodule

// ===== src/ptc_in_reg.sv =====
module ptc_in_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ptc_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // [9:0] sample
    input  logic [0:0]                          i_s_tuser,   // [0] kind
    input  logic                                i_take,
    output logic                                o_valid,
    output ptc_pkg::t_item                      o_item
);
    import ptc_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_s_tready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.kind   <= i_s_tuser[0];
            r_item.sample <= i_s_tdata[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== src/ptc_pi_step.sv =====
module ptc_pi_step (
    input  logic [ptc_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic [ptc_pkg::SAMPLE_BITS-1:0]   i_target,
    input  logic [ptc_pkg::COUNT_W-1:0]       i_count,
    input  logic [ptc_pkg::GAIN_W-1:0]        i_gain,
    input  logic signed [ptc_pkg::INT_W-1:0]  i_integral,
    output ptc_pkg::t_pi_res                  o_res
);
    import ptc_pkg::*;

    logic signed [SAMPLE_BITS:0]   dp;
    logic signed [INT_W:0]         di_wide;
    logic signed [INT_W-1:0]       di;
    logic signed [NEXT_W-1:0]      next_raw;
    logic signed [SAMPLE_BITS+2:0] dp_x;
    logic signed [SAMPLE_BITS+2:0] tgt_x2;
    logic signed [SAMPLE_BITS+1:0] dp_y;
    logic signed [SAMPLE_BITS+1:0] tgt_y;
    logic [GAIN_W:0]               g;

    assign dp      = $signed({1'b0, i_sample}) - $signed({1'b0, i_target});
    assign di_wide = $signed({i_integral[INT_W-1], i_integral}) + (INT_W+1)'(dp);

    // saturate to the signed 32-bit range
    always_comb begin
        if (di_wide[INT_W] != di_wide[INT_W-1]) begin
            di = di_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            di = di_wide[INT_W-1:0];
        end
    end

    assign next_raw = $signed(NEXT_W'({1'b0, i_count}))
                    + NEXT_W'(dp >>> PI_SHIFT_A)
                    + NEXT_W'(di >>> PI_SHIFT_A)
                    + NEXT_W'(di >>> PI_SHIFT_B)
                    + (dp[SAMPLE_BITS] ? -NEXT_W'(1) : NEXT_W'(1));

    assign dp_x   = (SAMPLE_BITS+3)'(dp);
    assign tgt_x2 = $signed({2'b00, i_target, 1'b0});
    assign dp_y   = (SAMPLE_BITS+2)'(dp);
    assign tgt_y  = $signed({2'b00, i_target});

    // gain step: doubled on a large error, else plus two or plus one
    always_comb begin
        if (dp_x > tgt_x2) begin
            g = {i_gain, 1'b0};
        end else if (dp_y > tgt_y) begin
            g = {1'b0, i_gain} + (GAIN_W+1)'(2);
        end else begin
            g = {1'b0, i_gain} + (GAIN_W+1)'(1);
        end
    end

    always_comb begin
        o_res.integral  = di;
        o_res.gain      = i_gain;
        o_res.top_retry = 1'b0;
        if (next_raw > $signed(NEXT_W'(COUNT_MAX))) begin
            if (i_gain == GAIN_W'(GAIN_MAX)) begin
                o_res.top_retry = 1'b1;
                o_res.count     = COUNT_W'(COUNT_MAX);
            end else begin
                if (g == '0) begin
                    o_res.gain = GAIN_W'(1);
                end else if (g > (GAIN_W+1)'(GAIN_MAX)) begin
                    o_res.gain = GAIN_W'(GAIN_MAX);
                end else begin
                    o_res.gain = g[GAIN_W-1:0];
                end
                o_res.count = COUNT_W'(COUNT_MID);
            end
        end else if (next_raw[NEXT_W-1]) begin
            o_res.count = '0;
        end else begin
            o_res.count = next_raw[COUNT_W-1:0];
        end
    end

endmodule

// ===== test/tb_proximity_crosstalk_calibrator_top.sv =====
`timescale 1ns / 1ps

module tb_proximity_crosstalk_calibrator_top;
    import ptc_pkg::*;

    // per setting, the number of random requests, not counting stray samples sent while idle or done
    localparam int PHASE_ITEMS = 144;
    localparam int N_DIRECTED  = 25;
    localparam int N_SETTINGS  = 8;
    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;

    // one result as the block reports it
    typedef struct packed {
        t_status               status;
        logic [COUNT_W-1:0]    count;
        logic [GAIN_W-1:0]     gain;
        logic [OFFSET_W-1:0]   offset;
    } calib_result_t;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;
        calib_result_t          want;
    } calib_row_t;

    localparam calib_result_t RES_NONE    = '{ST_STARTED, 7'd0, 4'd0, 11'd0};
    localparam calib_result_t RES_IGNORED = '{ST_IGNORED, 7'd0, 4'd1, 11'd0};
    localparam calib_result_t RES_STARTED = '{ST_STARTED, 7'd0, 4'd1, 11'd0};
    localparam calib_result_t RES_FOUND_0 = '{ST_FOUND,   7'd0, 4'd1, 11'd0};

    // directed walk: idle sample, start, the ignored first sample, pi steps into
    // gain steps, a zero reading into bisection, full-range halving, search end,
    // averaging of full-scale samples, sample while done, restart, instant finish
    localparam calib_row_t DIRECTED [N_DIRECTED] = '{
        '{KIND_SAMPLE, 10'd1023, 1'b1, RES_IGNORED},
        '{KIND_START,  10'd0,    1'b1, RES_STARTED},
        '{KIND_SAMPLE, 10'd1023, 1'b1, RES_IGNORED},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd0,    1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd500,  1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd50,   1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd0,    1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd0,    1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd1023, 1'b0, RES_NONE},
        '{KIND_SAMPLE, 10'd0,    1'b0, RES_NONE},
        '{KIND_START,  10'd1023, 1'b1, RES_STARTED},
        '{KIND_SAMPLE, 10'd0,    1'b1, RES_IGNORED},
        '{KIND_SAMPLE, 10'd0,    1'b1, RES_FOUND_0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [IN_TDATA_W-1:0]         i_s_tdata;
    logic [0:0]                    i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [OUT_TDATA_W-1:0]        o_m_tdata;
    logic [STATUS_W-1:0]           o_m_tuser;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic                          i_cfg_index;
    logic [SAMPLE_BITS-1:0]        i_cfg_data;

    // side info that travels with the request on the input stream
    logic                          row_typed;
    calib_result_t                 row_want;

    proximity_crosstalk_calibrator_top dut (.*);

    // calibration tracker: registers and search/average state
    logic [SAMPLE_BITS-1:0]        m_target;
    logic [SAMPLE_BITS-1:0]        m_full;
    t_phase                        m_phase;
    logic                          m_first;
    logic                          m_top_retry;
    logic                          m_pi;
    logic [COUNT_W-1:0]            m_count;
    logic [GAIN_W-1:0]             m_gain;
    logic [COUNT_W-1:0]            m_lo;
    logic [COUNT_W-1:0]            m_hi;
    logic signed [INT_W-1:0]       m_integ;
    logic [IDX_W-1:0]              m_avg_n;
    logic [SUM_W-1:0]              m_sum;

    calib_result_t                 calib_results_due [$];

    int n_fail;
    int n_sent;
    int n_checked;
    int n_cfg;
    int n_done_runs;
    int n_bisect;
    int n_top_retries;
    int burst_left;
    logic [9:0] rx_cycle;

    // ---------------------------------------------------------------- tracker

    function automatic void restart_search();
        m_phase     = PH_SEARCH;
        m_first     = 1'b1;
        m_top_retry = 1'b0;
        m_pi        = 1'b1;
        m_count     = '0;
        m_gain      = GAIN_W'(1);
        m_lo        = '0;
        m_hi        = COUNT_W'(COUNT_MAX);
        m_integ     = '0;
        m_avg_n     = '0;
        m_sum       = '0;
    endfunction

    function automatic void enter_averaging();
        m_phase = PH_AVG;
        m_avg_n = '0;
        m_sum   = '0;
    endfunction

    // one sample of the crosstalk search
    function automatic t_status search_update(input logic [SAMPLE_BITS-1:0] s);
        longint sl, tl, cl, il, dp, di, nxt, lo_l, hi_l;
        int g;
        if (m_first) begin
            m_first = 1'b0;
            return ST_IGNORED;
        end
        // a nonzero reading after the last try at top gain ends the search
        if (m_top_retry && s != 0) begin
            enter_averaging();
            return ST_FOUND;
        end
        m_top_retry = 1'b0;
        if (m_count != 0) begin
            if (s == 0) begin
                m_hi = m_count;
                m_pi = 1'b0;
            end else if (s <= m_target || m_count == m_lo || m_count == m_hi) begin
                enter_averaging();
                return ST_FOUND;
            end
        end else if (s <= m_target) begin
            enter_averaging();
            return ST_FOUND;
        end

        sl = s;
        tl = m_target;
        cl = m_count;
        if (m_pi) begin
            dp = sl - tl;
            il = m_integ;
            di = il + dp;
            if (di > INTEG_MAX) di = INTEG_MAX;
            if (di < INTEG_MIN) di = INTEG_MIN;
            m_integ = di[INT_W-1:0];
            // shifts on signed values round toward minus infinity
            nxt = cl + (dp >>> PI_SHIFT_A) + (di >>> PI_SHIFT_A) + (di >>> PI_SHIFT_B)
                + ((dp >= 0) ? 1 : -1);
            if (nxt > COUNT_MAX) begin
                if (m_gain == GAIN_W'(GAIN_MAX)) begin
                    m_top_retry = 1'b1;
                    n_top_retries++;
                    nxt = COUNT_MAX;
                end else begin
                    g = m_gain;
                    if (dp > 2 * tl) g = g << 1;
                    else if (dp > tl) g = g + 2;
                    else g = g + 1;
                    if (g == 0) g = 1;
                    else if (g > GAIN_MAX) g = GAIN_MAX;
                    m_gain = g[GAIN_W-1:0];
                    nxt = COUNT_MID;
                end
            end
        end else begin
            n_bisect++;
            if (s > m_target) m_lo = m_count;
            lo_l = m_lo;
            hi_l = m_hi;
            if (s < m_full && s > m_target) nxt = cl + 1;
            else nxt = (lo_l + hi_l) >>> 1;
        end
        if (nxt < 0) nxt = 0;
        if (nxt > COUNT_MAX) nxt = COUNT_MAX;
        m_count = nxt[COUNT_W-1:0];
        return ST_STEP;
    endfunction

    // expected result of one accepted request
    function automatic calib_result_t calib_step(input logic kind,
                                                 input logic [SAMPLE_BITS-1:0] s);
        calib_result_t r;
        r.status = ST_IGNORED;
        r.offset = '0;
        if (kind == KIND_START) begin
            restart_search();
            r.status = ST_STARTED;
        end else if (m_phase == PH_SEARCH) begin
            r.status = search_update(s);
        end else if (m_phase == PH_AVG) begin
            // the first two samples settle the sensor and are dropped
            if (m_avg_n >= IDX_W'(AVG_DROP)) m_sum = m_sum + SUM_W'(s);
            m_avg_n = m_avg_n + IDX_W'(1);
            if (m_avg_n >= IDX_W'(AVG_LAST)) begin
                r.offset = OFFSET_W'((m_sum >> AVG_SHIFT) + OFFSET_ADD);
                m_phase  = PH_DONE;
                r.status = ST_DONE;
            end else begin
                r.status = ST_AVG;
            end
        end
        r.count = m_count;
        r.gain  = m_gain;
        return r;
    endfunction

    // ---------------------------------------------------------------- monitor

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    // all handshakes are sampled here, before the edge updates the block
    always @(posedge i_clk) begin
        calib_result_t exp_r, pred;
        if (!i_rst_n) begin
            m_target = SAMPLE_BITS'(100);
            m_full   = SAMPLE_BITS'(1023);
            restart_search();
            m_phase  = PH_IDLE;
        end else begin
            // results first: a request accepted at this edge cannot answer yet
            if (o_m_tvalid && i_m_tready) begin
                if (calib_results_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d", o_m_tuser);
                    n_fail++;
                end else begin
                    exp_r = calib_results_due.pop_front();
                    check_field("status", exp_r.status, o_m_tuser);
                    check_field("fine_count", exp_r.count, o_m_tdata[6:0]);
                    check_field("fine_gain", exp_r.gain, o_m_tdata[10:7]);
                    check_field("offset_value", exp_r.offset, o_m_tdata[21:11]);
                    n_checked++;
                    if (exp_r.status == ST_DONE) n_done_runs++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_TARGET) m_target = i_cfg_data;
                else m_full = i_cfg_data;
                n_cfg++;
            end
            if (i_s_tvalid && o_s_tready) begin
                pred = calib_step(i_s_tuser[0], i_s_tdata[SAMPLE_BITS-1:0]);
                calib_results_due.push_back(row_typed ? row_want : pred);
                n_sent++;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: windows of always ready, coin flips, a regular hole, long stalls
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= ($urandom_range(1, 0) == 1);
            2'd2: i_m_tready <= (rx_cycle[2:0] != 3'd0);
            default: i_m_tready <= (rx_cycle[4:0] > 5'd11);
        endcase
    end

    // sender pacing: bursts of random length, random gaps; ends at a falling edge
    task automatic pace_sender();
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(40, 1);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // present one request and hold it until accepted
    task automatic push_req(input logic kind, input logic [SAMPLE_BITS-1:0] s,
                            input logic typed, input calib_result_t want);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - SAMPLE_BITS){1'b0}}, s};
        i_s_tuser  <= kind;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // register write, only once every outstanding result is back
    task automatic write_reg(input logic idx, input logic [SAMPLE_BITS-1:0] val);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (calib_results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // search readings shaped by how often a run should end early
    function automatic logic [SAMPLE_BITS-1:0] search_sample(input int low_pct);
        int r;
        r = $urandom_range(99, 0);
        if (r < low_pct / 2) return '0;
        if (r < low_pct) return SAMPLE_BITS'($urandom_range(m_target, 0));
        if (r < low_pct + 10) return SAMPLE_BITS'($urandom_range(1023, m_full));
        if (r < low_pct + 15) return SAMPLE_BITS'(1023);
        if (m_target == SAMPLE_BITS'(1023)) return SAMPLE_BITS'(1023);
        return SAMPLE_BITS'($urandom_range(1023, m_target + 1));
    endfunction

    // mostly whole calibrations with random readings, some aborts and stray samples
    task automatic random_calibrations(input int quota);
        int n, pick, low_pct;
        logic k;
        logic [SAMPLE_BITS-1:0] s;
        n = 0;
        low_pct = 12;
        while (n < quota) begin
            pace_sender();
            pick = $urandom_range(99, 0);
            s = SAMPLE_BITS'($urandom_range(1023, 0));
            if (m_phase == PH_IDLE || m_phase == PH_DONE) begin
                if (pick < 15) begin
                    k = KIND_SAMPLE;    // ignored, not counted
                end else begin
                    k = KIND_START;
                    case ($urandom_range(2, 0))
                        0: low_pct = 4;
                        1: low_pct = 12;
                        default: low_pct = 30;
                    endcase
                    n++;
                end
            end else if (pick < 3) begin
                k = KIND_START;         // restart in the middle of a run
                n++;
            end else begin
                k = KIND_SAMPLE;
                if (m_phase == PH_SEARCH) s = search_sample(low_pct);
                n++;
            end
            push_req(k, s, 1'b0, RES_NONE);
        end
    endtask

    initial begin
        logic [SAMPLE_BITS-1:0] t_lvl, f_lvl;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        i_m_tready    = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_TARGET;
        i_cfg_data    = '0;
        row_typed     = 1'b0;
        row_want      = RES_NONE;
        rx_cycle      = '0;
        burst_left    = 0;
        n_fail        = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_cfg         = 0;
        n_done_runs   = 0;
        n_bisect      = 0;
        n_top_retries = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reset register values
        for (int i = 0; i < N_DIRECTED; i++) begin
            pace_sender();
            push_req(DIRECTED[i].kind, DIRECTED[i].sample, DIRECTED[i].typed,
                     DIRECTED[i].want);
        end

        // random calibrations under several register settings
        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p > 0) begin
                case (p)
                    1: begin t_lvl = 10'd0;    f_lvl = 10'd1023; end
                    2: begin t_lvl = 10'd1023; f_lvl = 10'd1023; end
                    3: begin t_lvl = 10'd50;   f_lvl = 10'd0;    end
                    4: begin t_lvl = 10'd0;    f_lvl = 10'd0;    end
                    5: begin
                        t_lvl = SAMPLE_BITS'($urandom_range(1023, 0));
                        f_lvl = SAMPLE_BITS'($urandom_range(1023, 0));
                    end
                    6: begin
                        t_lvl = SAMPLE_BITS'($urandom_range(200, 0));
                        f_lvl = SAMPLE_BITS'($urandom_range(1023, 500));
                    end
                    default: begin t_lvl = 10'd100; f_lvl = 10'd1023; end
                endcase
                write_reg(CFG_TARGET, t_lvl);
                write_reg(CFG_FULL, f_lvl);
            end
            random_calibrations(PHASE_ITEMS);
        end

        // drain and let the pipeline settle
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (calib_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d requests, %0d checked results, %0d register writes",
                 n_sent, n_checked, n_cfg);
        $display("%0d calibrations completed, %0d bisection steps, %0d last tries at top gain",
                 n_done_runs, n_bisect, n_top_retries);
        if (n_fail == 0) begin
            $display("** proximity_crosstalk_calibrator_top: PASSED **");
        end else begin
            $display("** proximity_crosstalk_calibrator_top: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("** proximity_crosstalk_calibrator_top: FAILED **");
        $finish;
    end

endmodule
